[design/bnfpa_pkg.sv]
// shared types, codes and helpers of the next-fit port allocator
package bnfpa_pkg;

  localparam int PORT_W    = 16;
  localparam int POOL_W    = 11;
  localparam int WORD_BITS = 32;
  localparam int BIT_W     = 5;

  localparam logic [1:0] CMD_TAKE   = 2'd0;
  localparam logic [1:0] CMD_RETURN = 2'd1;
  localparam logic [1:0] CMD_MARK   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_OUTSIDE   = 2'd2;
  localparam logic [1:0] ST_BADCFG    = 2'd3;

  localparam logic CFG_BASE_PORT = 1'b0;
  localparam logic CFG_POOL_SIZE = 1'b1;

  localparam logic [POOL_W-1:0] POOL_RESET = 11'd1024;
  localparam logic [PORT_W:0]   PORT_LIMIT = 17'd65535;

  typedef struct packed {
    logic [1:0]        command;
    logic [PORT_W-1:0] port;
  } in_req_t;

  typedef struct packed {
    logic [PORT_W-1:0] granted_port;
    logic [1:0]        status;
    logic [POOL_W-1:0] free_count;
  } out_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_MODIFY,
    S_RESP,
    S_RC_START,
    S_RECOUNT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       rd_first;
    logic       rd_next;
    logic       rd_wrap;
    logic       grant;
    logic       modify;
    logic       rc_clear;
    logic       rc_acc;
    logic       res_load;
    logic [1:0] res_status;
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic pool_wr;
    logic bad_cfg;
    logic pool_ok;
    logic cmd_take;
    logic cmd_port;
    logic outside;
    logic exhausted;
    logic hit;
    logic last;
    logic phase;
  } dp_sts_t;

  function automatic logic [5:0] popcount32(input logic [WORD_BITS-1:0] w);
    logic [3:0] byte_cnt [4];
    logic [5:0] sum;
    for (int b = 0; b < 4; b++) begin
      byte_cnt[b] = 4'd0;
      for (int i = 0; i < 8; i++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(w[8*b+i]);
      end
    end
    sum = 6'(byte_cnt[0]) + 6'(byte_cnt[1]) + 6'(byte_cnt[2]) + 6'(byte_cnt[3]);
    return sum;
  endfunction

endpackage

[design/bnfpa_ctrl.sv]
// controller state machine of the next-fit port allocator
module bnfpa_ctrl import bnfpa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_ctl_t ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (sts.bad_cfg) begin
          state_nxt = S_RESP;
        end else if (sts.cmd_take) begin
          state_nxt = sts.exhausted ? S_RESP : S_SCAN;
        end else if (sts.cmd_port) begin
          state_nxt = sts.outside ? S_RESP : S_MODIFY;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_SCAN: begin
        if (sts.hit || (sts.last && sts.phase)) state_nxt = S_RESP;
      end
      S_MODIFY: state_nxt = S_RESP;
      S_RESP: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      S_RC_START: state_nxt = sts.pool_ok ? S_RECOUNT : S_IDLE;
      S_RECOUNT: begin
        if (sts.last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // a new pool size needs the used count rebuilt
    if (sts.pool_wr) state_nxt = S_RC_START;
  end

  always_comb begin
    ctl       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.accept = in_valid;
      end
      S_DECODE: begin
        if (sts.bad_cfg) begin
          ctl.res_load   = 1'b1;
          ctl.res_status = ST_BADCFG;
        end else if (sts.cmd_take) begin
          if (sts.exhausted) begin
            ctl.res_load   = 1'b1;
            ctl.res_status = ST_EXHAUSTED;
          end else begin
            ctl.rd_first = 1'b1;
          end
        end else if (sts.cmd_port) begin
          if (sts.outside) begin
            ctl.res_load   = 1'b1;
            ctl.res_status = ST_OUTSIDE;
          end else begin
            ctl.rd_first = 1'b1;
          end
        end else begin
          ctl.res_load   = 1'b1;
          ctl.res_status = ST_OK;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          ctl.grant      = 1'b1;
          ctl.res_load   = 1'b1;
          ctl.res_status = ST_OK;
        end else if (sts.last) begin
          if (!sts.phase) begin
            ctl.rd_wrap = 1'b1;
          end else begin
            ctl.res_load   = 1'b1;
            ctl.res_status = ST_EXHAUSTED;
          end
        end else begin
          ctl.rd_next = 1'b1;
        end
      end
      S_MODIFY: begin
        ctl.modify     = 1'b1;
        ctl.res_load   = 1'b1;
        ctl.res_status = ST_OK;
      end
      S_RESP: out_valid = 1'b1;
      S_RC_START: begin
        ctl.rc_clear = 1'b1;
        ctl.rd_wrap  = sts.pool_ok;
      end
      S_RECOUNT: begin
        ctl.rc_acc  = 1'b1;
        ctl.rd_next = !sts.last;
      end
      default: ;
    endcase
  end

endmodule

[design/bnfpa_datapath.sv]
// bitmap memory, configuration, counters and result register of the port allocator
module bnfpa_datapath import bnfpa_pkg::*; #(
  parameter int MAX_POOL = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [PORT_W-1:0] cfg_data,
  input  in_req_t           in_data,
  input  dp_ctl_t           ctl,
  output dp_sts_t           sts,
  output out_res_t          out_data
);

  localparam int IDX_W  = $clog2(MAX_POOL);
  localparam int WORD_W = (IDX_W > BIT_W) ? IDX_W - BIT_W : 1;
  localparam int PIDX_W = WORD_W + BIT_W;
  localparam int NWORDS = (MAX_POOL + WORD_BITS - 1) / WORD_BITS;
  localparam int LW     = (WORD_W > POOL_W - BIT_W) ? WORD_W : POOL_W - BIT_W;
  localparam int MAXP_W = $clog2(MAX_POOL + 1);
  localparam int CW     = (MAXP_W > POOL_W) ? MAXP_W : POOL_W;

  logic [PORT_W-1:0]    base_port_r;
  logic [POOL_W-1:0]    pool_size_r;
  in_req_t              req_r;
  logic [POOL_W-1:0]    used_total_r, used_total_nxt;
  logic [PIDX_W-1:0]    rover_r;
  logic                 phase_r;
  logic [WORD_W-1:0]    cur_word_r;
  logic [WORD_BITS-1:0] mem_q_r;
  logic                 mem_qv_r;
  logic [NWORDS-1:0]    row_valid_r;
  out_res_t             res_r;
  logic [WORD_BITS-1:0] bitmap_mem [NWORDS];

  logic [PORT_W-1:0]    port_idx;
  logic [POOL_W-1:0]    pool_m1;
  logic [LW-1:0]        last_word, cur_ext;
  logic [WORD_W-1:0]    rover_word;
  logic [WORD_BITS-1:0] word_eff, hi_mask, lo_mask, free_bits, onehot, bit_sel, mod_word;
  logic [WORD_BITS-1:0] wr_word;
  logic [BIT_W-1:0]     ff;
  logic                 rd_en, wr_en, cur_bit, want;
  logic [WORD_W-1:0]    rd_addr;
  logic [PORT_W-1:0]    granted;
  logic [PORT_W:0]      pool_end;
  logic                 bad_cfg;

  assign port_idx   = req_r.port - base_port_r;
  assign pool_m1    = pool_size_r - 1'b1;
  assign last_word  = LW'(pool_m1[POOL_W-1:BIT_W]);
  assign cur_ext    = LW'(cur_word_r);
  assign rover_word = rover_r[PIDX_W-1:BIT_W];
  assign word_eff   = mem_qv_r ? mem_q_r : '0;
  assign pool_end   = {1'b0, base_port_r} + (PORT_W + 1)'(pool_size_r);
  assign bad_cfg    = (pool_size_r == '0) || (CW'(pool_size_r) > CW'(MAX_POOL))
                      || (pool_end > PORT_LIMIT);

  // entries at or past pool_size are never free
  always_comb begin
    if (cur_ext < last_word) begin
      hi_mask = '1;
    end else if (cur_ext == last_word) begin
      hi_mask = {WORD_BITS{1'b1}} >> (5'd31 - pool_m1[BIT_W-1:0]);
    end else begin
      hi_mask = '0;
    end
  end

  // first pass starts at the rover
  assign lo_mask   = (!phase_r && cur_word_r == rover_word) ?
                     ({WORD_BITS{1'b1}} << rover_r[BIT_W-1:0]) : '1;
  assign free_bits = ~word_eff & hi_mask & lo_mask;
  assign onehot    = free_bits & (~free_bits + 1'b1);

  always_comb begin
    ff = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_bits[i]) ff = BIT_W'(i);
    end
  end

  assign bit_sel  = {{(WORD_BITS-1){1'b0}}, 1'b1} << port_idx[BIT_W-1:0];
  assign cur_bit  = word_eff[port_idx[BIT_W-1:0]];
  assign want     = (req_r.command == CMD_MARK);
  assign mod_word = want ? (word_eff | bit_sel) : (word_eff & ~bit_sel);
  assign wr_en    = ctl.grant | ctl.modify;
  assign wr_word  = ctl.grant ? (word_eff | onehot) : mod_word;
  assign granted  = base_port_r + PORT_W'({cur_word_r, ff});

  assign rd_en = ctl.rd_first | ctl.rd_next | ctl.rd_wrap;
  always_comb begin
    if (ctl.rd_first) begin
      rd_addr = (req_r.command == CMD_TAKE) ? rover_word : port_idx[PIDX_W-1:BIT_W];
    end else if (ctl.rd_next) begin
      rd_addr = cur_word_r + 1'b1;
    end else begin
      rd_addr = '0;
    end
  end

  always_comb begin
    used_total_nxt = used_total_r;
    if (ctl.rc_clear) begin
      used_total_nxt = '0;
    end else if (ctl.rc_acc) begin
      used_total_nxt = used_total_r + POOL_W'(popcount32(word_eff & hi_mask));
    end else if (ctl.grant) begin
      used_total_nxt = used_total_r + 1'b1;
    end else if (ctl.modify && (cur_bit != want)) begin
      used_total_nxt = want ? used_total_r + 1'b1 : used_total_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) bitmap_mem[cur_word_r] <= wr_word;
    if (rd_en) mem_q_r <= bitmap_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_port_r  <= '0;
      pool_size_r  <= POOL_RESET;
      used_total_r <= '0;
      rover_r      <= '0;
      phase_r      <= 1'b0;
      cur_word_r   <= '0;
      mem_qv_r     <= 1'b0;
      row_valid_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE_PORT: base_port_r <= cfg_data;
          CFG_POOL_SIZE: pool_size_r <= cfg_data[POOL_W-1:0];
        endcase
      end
      used_total_r <= used_total_nxt;
      if (rd_en) begin
        cur_word_r <= rd_addr;
        mem_qv_r   <= row_valid_r[rd_addr];
      end
      if (ctl.rd_first) phase_r <= 1'b0;
      if (ctl.rd_wrap)  phase_r <= 1'b1;
      if (wr_en) row_valid_r[cur_word_r] <= 1'b1;
      if (ctl.grant) rover_r <= {cur_word_r, ff};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) req_r <= in_data;
    if (ctl.res_load) begin
      res_r.status       <= ctl.res_status;
      res_r.granted_port <= ctl.grant ? granted : '0;
      res_r.free_count   <= bad_cfg ? '0 : pool_size_r - used_total_nxt;
    end
  end

  assign out_data = res_r;

  assign sts.pool_wr   = cfg_we && (cfg_index == CFG_POOL_SIZE);
  assign sts.bad_cfg   = bad_cfg;
  assign sts.pool_ok   = (pool_size_r != '0) && (CW'(pool_size_r) <= CW'(MAX_POOL));
  assign sts.cmd_take  = (req_r.command == CMD_TAKE);
  assign sts.cmd_port  = (req_r.command == CMD_RETURN) || (req_r.command == CMD_MARK);
  assign sts.outside   = (port_idx >= PORT_W'(pool_size_r));
  assign sts.exhausted = (used_total_r >= pool_size_r);
  assign sts.hit       = |free_bits;
  assign sts.last      = (cur_ext >= last_word);
  assign sts.phase     = phase_r;

endmodule

[design/bitmap_next_fit_port_allocator_unit.sv]
// top level of the next-fit port allocator
// Hands out ports base_port + i from a pool of pool_size entries tracked by a used-bit map
// held in a memory of 32-bit words (up to MAX_POOL entries). One request is in work at a
// time. A take is decoded and then scans the bitmap words visited by the find-first
// search: from the rover's word to the pool's last word, then from word 0 again if nothing
// was free; the single memory read port and the 32-bit find-first unit make this scan go
// word by word. Return and mark read, modify and write one bitmap word. Exhausted,
// outside-pool and bad-configuration results go from decode straight to the response. The
// result then waits in the output register until taken. Writing pool_size starts a recount
// of the used bits below the new size, during which no request is taken. The bitmap reads
// as all free after reset through per-word valid bits, so there is no clearing pass.
module bitmap_next_fit_port_allocator_unit import bnfpa_pkg::*; #(
  parameter int MAX_POOL = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [PORT_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_req_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_res_t          out_data
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  bnfpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  bnfpa_datapath #(
    .MAX_POOL (MAX_POOL)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .ctl       (ctl),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

[verif/bitmap_next_fit_port_allocator_unit_tb.sv]
// testbench for the next-fit port allocator: shadow pool model, scoreboard and random traffic
`timescale 1ns / 1ps

import bnfpa_pkg::*;

localparam int POOL_MAX = 1024;
localparam logic [1:0] CMD_UNUSED = 2'd3;

class pool_mirror;
  bit       used_bits [POOL_MAX];
  int       base_port;
  int       pool_size;
  int       rover;
  int       used_cnt;
  int       mismatches;
  out_res_t pending_replies [$];

  function new();
    base_port  = 0;
    pool_size  = POOL_RESET;
    rover      = 0;
    used_cnt   = 0;
    mismatches = 0;
    foreach (used_bits[i]) used_bits[i] = 1'b0;
  endfunction

  function void write_reg(logic idx, logic [PORT_W-1:0] data);
    if (idx == CFG_BASE_PORT) begin
      base_port = data;
    end else begin
      pool_size = data & 16'h07FF;
      // only entries below the new size count as used
      used_cnt = 0;
      for (int i = 0; i < POOL_MAX && i < pool_size; i++) used_cnt += used_bits[i];
    end
  endfunction

  function int first_free(int from);
    for (int i = from; i < pool_size; i++) begin
      if (!used_bits[i]) return i;
    end
    return pool_size;
  endfunction

  // works out the reply of one accepted request and updates the shadow pool
  function void note_request(in_req_t req);
    out_res_t res;
    int       idx;
    bit       want;
    res = '0;
    if (pool_size == 0 || pool_size > POOL_MAX || base_port + pool_size > PORT_LIMIT) begin
      res.status = ST_BADCFG;
    end else begin
      case (req.command) inside
        CMD_TAKE: begin
          if (used_cnt >= pool_size) begin
            res.status = ST_EXHAUSTED;
          end else begin
            idx = first_free(rover);
            if (idx >= pool_size) begin
              rover = 0;
              idx = first_free(0);
            end
            if (idx < pool_size) begin
              used_bits[idx] = 1'b1;
              used_cnt++;
              rover = idx;
              res.granted_port = PORT_W'(base_port + idx);
            end else begin
              res.status = ST_EXHAUSTED;
            end
          end
        end
        CMD_RETURN, CMD_MARK: begin
          idx = (int'(req.port) - base_port) & 32'hFFFF;
          if (idx >= pool_size) begin
            res.status = ST_OUTSIDE;
          end else begin
            want = (req.command == CMD_MARK);
            if (used_bits[idx] != want) begin
              used_bits[idx] = want;
              if (want) used_cnt++;
              else used_cnt--;
            end
          end
        end
        default: ;
      endcase
      res.free_count = POOL_W'(pool_size - used_cnt);
    end
    pending_replies.push_back(res);
  endfunction

  function void check_reply(out_res_t got);
    out_res_t want;
    bit       bad;
    if (pending_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected reply: port %0d status %0d free %0d",
                 got.granted_port, got.status, got.free_count);
      return;
    end
    want = pending_replies.pop_front();
    bad = (got.granted_port !== want.granted_port) || (got.status !== want.status) ||
          (got.free_count !== want.free_count);
    if (bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp port %0d st %0d free %0d, got port %0d st %0d free %0d",
                 want.granted_port, want.status, want.free_count,
                 got.granted_port, got.status, got.free_count);
    end
  endfunction
endclass

module bitmap_next_fit_port_allocator_unit_tb;

  localparam int QUIET_LIMIT = 3000;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_index;
  logic [PORT_W-1:0] cfg_data;
  logic              in_valid;
  logic              in_ready;
  in_req_t           in_data;
  logic              out_valid;
  logic              out_ready;
  out_res_t          out_data;

  pool_mirror mirror;
  int         send_idle;
  int         take_idle;
  int         quiet_cycles;

  bitmap_next_fit_port_allocator_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // reply side: check on handshake, then pick the next ready
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) mirror.check_reply(out_data);
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= take_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  task automatic send_req(input logic [1:0] cmd, input logic [PORT_W-1:0] port);
    in_req_t req;
    req.command = cmd;
    req.port    = port;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.note_request(req);
  endtask

  task automatic drain_pool();
    in_valid <= 1'b0;
    while (mirror.pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_pool(input int base, input int size);
    drain_pool();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BASE_PORT;
    cfg_data  <= PORT_W'(base);
    @(posedge clk);
    mirror.write_reg(CFG_BASE_PORT, PORT_W'(base));
    cfg_index <= CFG_POOL_SIZE;
    cfg_data  <= PORT_W'(size);
    @(posedge clk);
    mirror.write_reg(CFG_POOL_SIZE, PORT_W'(size));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int sender_pct, input int receiver_pct, input int target);
    int          done;
    int          count;
    int          roll;
    int          size;
    int          base;
    int          span;
    logic [1:0]  cmd;
    logic [15:0] port;
    send_idle = sender_pct;
    take_idle = receiver_pct;
    done = 0;
    while (done < target) begin
      roll = $urandom_range(0, 9);
      if (roll < 5) size = $urandom_range(1, 40);
      else if (roll < 7) size = $urandom_range(41, POOL_MAX);
      else if (roll < 8) size = POOL_MAX;
      else if (roll < 9) size = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(POOL_MAX + 1, 2047);
      else size = $urandom_range(1, 64);
      // now and then a base that runs the pool past the top port
      if ($urandom_range(0, 7) == 0) base = $urandom_range(0, 65535);
      else base = $urandom_range(0, 65535 - size);
      set_pool(base, size);
      // a bad setting only rejects requests, keep those runs short
      if (size == 0 || size > POOL_MAX || base + size > 65535) count = 5;
      else count = $urandom_range(25, 50);
      span = (mirror.pool_size > 0) ? mirror.pool_size : 1;
      for (int k = 0; k < count; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) cmd = CMD_TAKE;
        else if (roll < 78) cmd = CMD_RETURN;
        else if (roll < 95) cmd = CMD_MARK;
        else cmd = CMD_UNUSED;
        roll = $urandom_range(0, 99);
        if (roll < 75) port = 16'(mirror.base_port + $urandom_range(0, span - 1));
        else if (roll < 88) port = 16'(mirror.base_port + span + $urandom_range(0, 3));
        else port = 16'($urandom);
        send_req(cmd, port);
      end
      if (count > 5) done += count;
    end
  endtask

  initial begin
    mirror = new();
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_BASE_PORT;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    send_idle = 9;
    take_idle = 75;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default pool straight out of reset
    send_req(CMD_TAKE, 16'hFFFF);
    send_req(CMD_TAKE, 16'h0000);
    send_req(CMD_RETURN, 16'd0);
    send_req(CMD_TAKE, 16'd0);
    send_req(CMD_MARK, 16'hFFFF);
    send_req(CMD_MARK, 16'd1023);
    send_req(CMD_MARK, 16'd1023);
    send_req(CMD_RETURN, 16'd1023);
    send_req(CMD_RETURN, 16'd1023);
    send_req(CMD_UNUSED, 16'hFFFF);

    // small pool: fill up, port below base wraps to outside, return one and take it again
    set_pool(100, 4);
    repeat (4) send_req(CMD_TAKE, 16'd0);
    send_req(CMD_RETURN, 16'd99);
    send_req(CMD_RETURN, 16'd104);
    send_req(CMD_RETURN, 16'd101);
    send_req(CMD_TAKE, 16'd0);

    // shrink below the used entries, then take from the full pool
    set_pool(100, 2);
    send_req(CMD_TAKE, 16'd0);

    // pool ending just below the top port
    set_pool(65535 - POOL_MAX, POOL_MAX);
    send_req(CMD_TAKE, 16'd0);
    send_req(CMD_MARK, 16'hFFFF);
    send_req(CMD_RETURN, 16'hFFFF);

    // bad settings
    set_pool(65535, 1);
    send_req(CMD_TAKE, 16'd0);
    set_pool(0, 0);
    send_req(CMD_RETURN, 16'd0);
    set_pool(0, 2047);
    send_req(CMD_MARK, 16'd0);
    set_pool(0, POOL_MAX + 1);
    send_req(CMD_TAKE, 16'd0);

    // single entry pool
    set_pool(0, 1);
    send_req(CMD_TAKE, 16'd0);
    send_req(CMD_TAKE, 16'd0);

    run_phase(9, 75, 290);
    run_phase(75, 9, 290);
    run_phase(0, 0, 290);

    drain_pool();
    repeat (20) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
design/bnfpa_pkg.sv
design/bnfpa_ctrl.sv
design/bnfpa_datapath.sv
design/bitmap_next_fit_port_allocator_unit.sv
verif/bitmap_next_fit_port_allocator_unit_tb.sv
